// File: rtl/nsstp_pkg.sv
// Shared types, sizes and helpers for the nested scope self-time profiler.
// Used by nsstp_alu, nsstp_store and nested_scope_self_time_profiler; no dependencies.
`default_nettype none

package nsstp_pkg;

  localparam int unsigned STACK_DEPTH = 256;
  localparam int unsigned MAX_OPS     = 16;
  localparam int unsigned TIME_W      = 64;

  localparam int unsigned STACK_AW = $clog2(STACK_DEPTH);
  localparam int unsigned OP_AW    = $clog2(MAX_OPS);
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned OP_W     = 8;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned TS_W     = 64;
  localparam int unsigned OUT_W    = 224;

  typedef enum logic [MODE_W-1:0] {
    MODE_START = 2'd0,
    MODE_ENTER = 2'd1,
    MODE_EXIT  = 2'd2,
    MODE_READ  = 2'd3
  } mode_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef logic [OP_AW-1:0]  op_idx_t;
  typedef logic [TIME_W-1:0] time_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // Control from the sequencer to the per-op counter store.
  typedef struct packed {
    logic    clear;
    logic    self_re;
    op_idx_t self_raddr;
    logic    self_we;
    op_idx_t self_waddr;
    logic    disp_re;
    op_idx_t disp_raddr;
    logic    disp_we;
    op_idx_t disp_waddr;
  } store_req_t;

  // True when the op has per-op counters.
  function automatic logic op_in_range(logic [OP_W-1:0] op);
    return {1'b0, op} < (OP_W + 1)'(MAX_OPS);
  endfunction

endpackage

`default_nettype wire

// File: rtl/nested_scope_self_time_profiler.sv
// Nested scope self-time profiler: top level with event sequencer and op stack memory.
// Depends on nsstp_pkg, nsstp_alu and nsstp_store.
//
// Each event is one input transfer (kind in tuser: start, enter, exit, read) and yields
// exactly one result transfer with the counters of the named op. An event occupies the
// block from its input transfer to the loading of the result register, and the input is
// ready again in the cycle after that load, so no new event is taken before the last one
// has reached the result register: the sequencer walks elapsed-time subtract, stack-top
// lookup, self-time read-modify-write and report read, and all time arithmetic goes
// through one shared TIME_W-bit adder while the op stack and per-op counters sit behind
// single-port, registered-read memories. A finished result waits in its own register, so
// the next event is taken while the result is still pending; a later result holds in the
// last step until the output register is free. Start clears the per-op counters at once.
`default_nettype none

module nested_scope_self_time_profiler (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [71:0]  s_axis_tdata,  // op[7:0], timestamp[71:8]
  input  logic [1:0]   s_axis_tuser,  // mode[1:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [223:0] m_axis_tdata   // dispatch_count[31:0], self_time[95:32],
                                      // all_enters[127:96], peak_depth[159:128],
                                      // overflow_count[191:160], depth[223:192]
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_ELAPSE = 6'b000010,
    S_FETCH  = 6'b000100,
    S_CREDIT = 6'b001000,
    S_REPORT = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  nsstp_pkg::mode_e              mode_q;
  logic [nsstp_pkg::OP_W-1:0]    op_q;
  nsstp_pkg::time_t              ts_q;
  nsstp_pkg::time_t              elapsed_q;
  nsstp_pkg::time_t              time_mark_q;
  nsstp_pkg::cnt_t               nest_depth_q;
  nsstp_pkg::cnt_t               all_disp_q;
  nsstp_pkg::cnt_t               deepest_q;
  nsstp_pkg::cnt_t               overflows_q;
  logic                          credit_en_q;
  nsstp_pkg::op_idx_t            credit_idx_q;
  logic [nsstp_pkg::OP_W-1:0]    stack_rd_q;
  logic                          out_valid_q;
  logic [nsstp_pkg::OUT_W-1:0]   out_data_q;

  logic [nsstp_pkg::OP_W-1:0]    op_stack_mem [nsstp_pkg::STACK_DEPTH];

  logic                          accept;
  logic                          top_ok;
  logic                          push_ok;
  logic                          op_ok;
  logic                          credit_en_d;
  nsstp_pkg::op_idx_t            credit_idx_d;
  nsstp_pkg::op_idx_t            op_idx;
  logic [nsstp_pkg::STACK_AW-1:0] top_idx;
  logic [nsstp_pkg::STACK_AW-1:0] push_idx;
  logic                          stack_we;
  nsstp_pkg::cnt_t               depth_inc;
  nsstp_pkg::alu_op_e            alu_op;
  nsstp_pkg::time_t              alu_a;
  nsstp_pkg::time_t              alu_b;
  nsstp_pkg::time_t              alu_y;
  nsstp_pkg::store_req_t         st_req;
  nsstp_pkg::time_t              self_rdata;
  nsstp_pkg::cnt_t               disp_rdata;
  logic                          out_free;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign op_ok    = nsstp_pkg::op_in_range(op_q);
  assign op_idx   = nsstp_pkg::OP_AW'(op_q);
  assign top_ok   = (nest_depth_q != '0) &&
                    (nest_depth_q <= nsstp_pkg::CNT_W'(nsstp_pkg::STACK_DEPTH));
  assign push_ok  = nest_depth_q < nsstp_pkg::CNT_W'(nsstp_pkg::STACK_DEPTH);
  assign top_idx  = nsstp_pkg::STACK_AW'(nest_depth_q - nsstp_pkg::CNT_W'(1));
  assign push_idx = nsstp_pkg::STACK_AW'(nest_depth_q);
  assign stack_we = (state_q == S_CREDIT) && (mode_q == nsstp_pkg::MODE_ENTER) && push_ok;
  assign depth_inc = (nest_depth_q == '1) ? nest_depth_q
                                          : nest_depth_q + nsstp_pkg::CNT_W'(1);

  // Enter credits the op on the stack top, exit credits the named op.
  always_comb begin
    credit_en_d  = 1'b0;
    credit_idx_d = op_idx;
    case (mode_q)
      nsstp_pkg::MODE_ENTER: begin
        credit_en_d  = top_ok && nsstp_pkg::op_in_range(stack_rd_q);
        credit_idx_d = nsstp_pkg::OP_AW'(stack_rd_q);
      end
      nsstp_pkg::MODE_EXIT: begin
        credit_en_d = op_ok;
      end
      default: begin
        credit_en_d = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (state_q == S_ELAPSE) begin
      alu_op = nsstp_pkg::ALU_SUB;
      alu_a  = ts_q;
      alu_b  = time_mark_q;
    end else begin
      alu_op = nsstp_pkg::ALU_ADD;
      alu_a  = self_rdata;
      alu_b  = elapsed_q;
    end
  end

  nsstp_alu u_alu (
    .op_i (alu_op),
    .a_i  (alu_a),
    .b_i  (alu_b),
    .y_o  (alu_y)
  );

  always_comb begin
    st_req            = '0;
    st_req.self_raddr = op_idx;
    st_req.disp_raddr = op_idx;
    st_req.self_waddr = credit_idx_q;
    st_req.disp_waddr = op_idx;
    case (state_q)
      S_ELAPSE: begin
        st_req.disp_re = 1'b1;
      end
      S_FETCH: begin
        st_req.self_re    = 1'b1;
        st_req.self_raddr = credit_idx_d;
      end
      S_CREDIT: begin
        st_req.clear   = (mode_q == nsstp_pkg::MODE_START);
        st_req.self_we = credit_en_q;
        st_req.disp_we = (mode_q == nsstp_pkg::MODE_ENTER) && op_ok;
      end
      S_REPORT: begin
        st_req.self_re = 1'b1;
        st_req.disp_re = 1'b1;
      end
      default: begin
        st_req.clear = 1'b0;
      end
    endcase
  end

  nsstp_store u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (st_req),
    .self_wdata_i (alu_y),
    .disp_wdata_i (disp_rdata + nsstp_pkg::CNT_W'(1)),
    .self_rdata_o (self_rdata),
    .disp_rdata_o (disp_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (accept) state_d = S_ELAPSE;
      S_ELAPSE: state_d = S_FETCH;
      S_FETCH:  state_d = S_CREDIT;
      S_CREDIT: state_d = S_REPORT;
      S_REPORT: state_d = S_DONE;
      S_DONE:   if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Payload: event fields, stack memory, intermediate values, result data.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= nsstp_pkg::mode_e'(s_axis_tuser);
      op_q   <= s_axis_tdata[nsstp_pkg::OP_W-1:0];
      ts_q   <= s_axis_tdata[nsstp_pkg::OP_W +: nsstp_pkg::TIME_W];
    end
    if (state_q == S_ELAPSE) begin
      elapsed_q  <= alu_y;
      stack_rd_q <= op_stack_mem[top_idx];
    end
    if (state_q == S_FETCH) begin
      credit_idx_q <= credit_idx_d;
    end
    if (stack_we) begin
      op_stack_mem[push_idx] <= op_q;
    end
    if ((state_q == S_DONE) && out_free) begin
      out_data_q <= {nest_depth_q, overflows_q, deepest_q, all_disp_q,
                     op_ok ? nsstp_pkg::TS_W'(self_rdata) : nsstp_pkg::TS_W'(0),
                     op_ok ? disp_rdata : nsstp_pkg::CNT_W'(0)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      credit_en_q  <= 1'b0;
      time_mark_q  <= '0;
      nest_depth_q <= '0;
      all_disp_q   <= '0;
      deepest_q    <= '0;
      overflows_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_FETCH) begin
        credit_en_q <= credit_en_d;
      end
      if (state_q == S_CREDIT) begin
        case (mode_q)
          nsstp_pkg::MODE_START: begin
            time_mark_q  <= ts_q;
            nest_depth_q <= '0;
            all_disp_q   <= '0;
            deepest_q    <= '0;
            overflows_q  <= '0;
          end
          nsstp_pkg::MODE_ENTER: begin
            time_mark_q  <= ts_q;
            nest_depth_q <= depth_inc;
            all_disp_q   <= all_disp_q + nsstp_pkg::CNT_W'(1);
            if (depth_inc > deepest_q) begin
              deepest_q <= depth_inc;
            end
            if (!push_ok) begin
              overflows_q <= overflows_q + nsstp_pkg::CNT_W'(1);
            end
          end
          nsstp_pkg::MODE_EXIT: begin
            time_mark_q <= ts_q;
            if (nest_depth_q != '0) begin
              nest_depth_q <= nest_depth_q - nsstp_pkg::CNT_W'(1);
            end
          end
          default: begin
            time_mark_q <= time_mark_q;
          end
        endcase
      end
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  a_deepest_covers_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    deepest_q >= nest_depth_q)
    else $error("deepest below current depth");

  a_store_clear_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_req.clear |-> !(st_req.self_we || st_req.disp_we))
    else $error("counter write during clear");

  a_counters_move_in_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_CREDIT) |=> ($stable(overflows_q) && $stable(nest_depth_q)))
    else $error("counter changed outside credit step");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_DONE) && !(out_valid_q && !m_axis_tready) |=> !out_valid_q)
    else $error("result loaded outside final step");

endmodule

`default_nettype wire

// File: rtl/nsstp_alu.sv
// Shared TIME_W-bit add/subtract unit of the profiler.
// Depends on nsstp_pkg.
`default_nettype none

module nsstp_alu (
  input  nsstp_pkg::alu_op_e op_i,
  input  nsstp_pkg::time_t   a_i,
  input  nsstp_pkg::time_t   b_i,
  output nsstp_pkg::time_t   y_o
);

  logic sub;

  assign sub = (op_i == nsstp_pkg::ALU_SUB);

  // One carry chain: subtract as add of the complement plus one.
  assign y_o = a_i + (sub ? ~b_i : b_i) + nsstp_pkg::TIME_W'(sub);

endmodule

`default_nettype wire

// File: rtl/nsstp_store.sv
// Per-op self-time and dispatch counter memories with valid bits for fast clearing.
// Depends on nsstp_pkg.
`default_nettype none

module nsstp_store (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  nsstp_pkg::store_req_t  req_i,
  input  nsstp_pkg::time_t       self_wdata_i,
  input  nsstp_pkg::cnt_t        disp_wdata_i,
  output nsstp_pkg::time_t       self_rdata_o,
  output nsstp_pkg::cnt_t        disp_rdata_o
);

  nsstp_pkg::time_t self_mem [nsstp_pkg::MAX_OPS];
  nsstp_pkg::cnt_t  disp_mem [nsstp_pkg::MAX_OPS];

  logic [nsstp_pkg::MAX_OPS-1:0] self_vld_q;
  logic [nsstp_pkg::MAX_OPS-1:0] disp_vld_q;
  nsstp_pkg::time_t              self_rd_q;
  nsstp_pkg::cnt_t               disp_rd_q;
  logic                          self_rv_q;
  logic                          disp_rv_q;

  always_ff @(posedge clk_i) begin
    if (req_i.self_we) begin
      self_mem[req_i.self_waddr] <= self_wdata_i;
    end
    if (req_i.disp_we) begin
      disp_mem[req_i.disp_waddr] <= disp_wdata_i;
    end
    if (req_i.self_re) begin
      self_rd_q <= self_mem[req_i.self_raddr];
    end
    if (req_i.disp_re) begin
      disp_rd_q <= disp_mem[req_i.disp_raddr];
    end
  end

  // An entry not written since the last start reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_vld_q <= '0;
      disp_vld_q <= '0;
      self_rv_q  <= 1'b0;
      disp_rv_q  <= 1'b0;
    end else begin
      if (req_i.clear) begin
        self_vld_q <= '0;
        disp_vld_q <= '0;
      end else begin
        if (req_i.self_we) begin
          self_vld_q[req_i.self_waddr] <= 1'b1;
        end
        if (req_i.disp_we) begin
          disp_vld_q[req_i.disp_waddr] <= 1'b1;
        end
      end
      if (req_i.self_re) begin
        self_rv_q <= self_vld_q[req_i.self_raddr];
      end
      if (req_i.disp_re) begin
        disp_rv_q <= disp_vld_q[req_i.disp_raddr];
      end
    end
  end

  assign self_rdata_o = self_rv_q ? self_rd_q : '0;
  assign disp_rdata_o = disp_rv_q ? disp_rd_q : '0;

endmodule

`default_nettype wire
